// ===== src/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Types, constants and helpers for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int unsigned MaxLine    = 128;
  localparam int unsigned MaxTypeLen = 4;
  localparam int unsigned MinLine    = 7;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [3:0] NibMask  = 4'hF;

  typedef enum logic [0:0] {
    CFG_TYPE     = 1'b0,
    CFG_TYPE_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SECOND = 3'd1,
    PH_TALKER = 3'd2,
    PH_NAME   = 3'd3,
    PH_BODY   = 3'd4,
    PH_HEX1   = 3'd5,
    PH_HEX2   = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    V_OK       = 3'd0,
    V_SHORT    = 3'd1,
    V_BADSTART = 3'd2,
    V_MISMATCH = 3'd3,
    V_CHECKSUM = 3'd4,
    V_TRUNC    = 3'd5
  } verdict_e;

  typedef struct packed {
    verdict_e   verdict;
    logic [7:0] talker;
    logic [7:0] length;
  } result_t;

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    logic [3:0] n;
    n = v & NibMask;
    if (n < 4'd10) begin
      return 8'h30 + {4'd0, n};
    end
    return 8'h41 + {4'd0, n} - 8'd10;
  endfunction

endpackage

// ===== src/nmea_sentence_checker.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Checks NMEA 0183 lines byte by byte and reports one verdict per CR LF.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless the input is stalled: each beat updates
// the line state in a single pass and, on the LF of a CR LF pair, loads the
// result register, which drives the verdict, talker byte and line length from
// the next cycle. Input is stalled only while that register holds an untaken beat.
module nmea_sentence_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [7:0]  talker_byte_o,
  output logic [7:0]  line_length_o
);

  logic [31:0]      sentence_type_q;
  logic [2:0]       sentence_type_len_q;
  logic             in_beat;
  logic             res_valid;
  nsc_pkg::result_t res;
  logic             out_valid_q, out_valid_d;
  nsc_pkg::result_t out_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_beat    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sentence_type_q     <= 32'd0;
      sentence_type_len_q <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (nsc_pkg::cfg_idx_e'(cfg_idx_i))
        nsc_pkg::CFG_TYPE:     sentence_type_q     <= cfg_data_i;
        nsc_pkg::CFG_TYPE_LEN: sentence_type_len_q <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  nsc_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .beat_i             (in_beat),
    .byte_i             (byte_in_i),
    .sentence_type_i    (sentence_type_q),
    .sentence_type_len_i(sentence_type_len_q),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = out_q.verdict;
  assign talker_byte_o = out_q.talker;
  assign line_length_o = out_q.length;

endmodule

// ===== src/nsc_parser.sv =====
// ----------------------------------------------------------------------------
// nsc_parser
// Per-byte line state and verdict logic; flags a result on each CR LF.
// ----------------------------------------------------------------------------
module nsc_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       byte_i,
  input  logic [31:0]      sentence_type_i,
  input  logic [2:0]       sentence_type_len_i,
  output logic             res_valid_o,
  output nsc_pkg::result_t res_o
);

  nsc_pkg::phase_e   phase_q, phase_d;
  nsc_pkg::verdict_e pending_q, pending_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] cnt_q, cnt_d;
  logic [2:0] pos_q, pos_d;
  logic       start_good_q, start_good_d;
  logic [7:0] talker_q, talker_d;
  logic       prev_cr_q, prev_cr_d;
  logic       overlong_q, overlong_d;

  logic       line_end;
  logic [3:0] name_len;
  logic [7:0] name_byte;
  logic       is_term;

  always_comb begin
    if ({1'b0, sentence_type_len_i} > 4'(nsc_pkg::MaxTypeLen)) begin
      name_len = 4'(nsc_pkg::MaxTypeLen);
    end else begin
      name_len = {1'b0, sentence_type_len_i};
    end
    if (pos_q[2]) begin
      name_byte = 8'd0;
    end else begin
      name_byte = sentence_type_i[{pos_q[1:0], 3'b000} +: 8];
    end
  end

  assign line_end = (byte_i == nsc_pkg::ChLf) && prev_cr_q;
  assign is_term  = (byte_i == nsc_pkg::ChStar) || (byte_i == nsc_pkg::ChComma);

  always_comb begin
    phase_d      = phase_q;
    pending_d    = pending_q;
    xor_d        = xor_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    start_good_d = start_good_q;
    talker_d     = talker_q;
    overlong_d   = overlong_q;
    prev_cr_d    = prev_cr_q;
    res_valid_o  = 1'b0;
    res_o        = '{verdict: nsc_pkg::V_OK, talker: talker_q, length: cnt_q};

    if (beat_i) begin
      if (cnt_q >= 8'(nsc_pkg::MaxLine)) begin
        overlong_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 8'd1;
      end
      if (cnt_d == 8'd3 && !overlong_d) begin
        talker_d = byte_i;
      end

      unique case (phase_q)
        nsc_pkg::PH_START: begin
          if (byte_i != nsc_pkg::ChDollar) begin
            pending_d = nsc_pkg::V_BADSTART;
            phase_d   = nsc_pkg::PH_DONE;
          end else begin
            phase_d = nsc_pkg::PH_SECOND;
          end
        end
        nsc_pkg::PH_SECOND: begin
          if (byte_i != nsc_pkg::ChG) begin
            pending_d = nsc_pkg::V_BADSTART;
            phase_d   = nsc_pkg::PH_DONE;
          end else begin
            start_good_d = 1'b1;
            xor_d        = byte_i;
            phase_d      = nsc_pkg::PH_TALKER;
          end
        end
        nsc_pkg::PH_TALKER: begin
          xor_d   = xor_q ^ byte_i;
          pos_d   = 3'd0;
          phase_d = nsc_pkg::PH_NAME;
        end
        nsc_pkg::PH_NAME: begin
          if (is_term) begin
            if ({1'b0, pos_q} < name_len) begin
              pending_d = nsc_pkg::V_MISMATCH;
              phase_d   = nsc_pkg::PH_DONE;
            end else if (byte_i == nsc_pkg::ChStar) begin
              phase_d = nsc_pkg::PH_HEX1;
            end else begin
              xor_d   = xor_q ^ byte_i;
              phase_d = nsc_pkg::PH_BODY;
            end
          end else if ({1'b0, pos_q} >= name_len || byte_i != name_byte) begin
            pending_d = nsc_pkg::V_MISMATCH;
            phase_d   = nsc_pkg::PH_DONE;
          end else begin
            xor_d = xor_q ^ byte_i;
            pos_d = pos_q + 3'd1;
          end
        end
        nsc_pkg::PH_BODY: begin
          if (byte_i == nsc_pkg::ChCr || byte_i == nsc_pkg::ChLf) begin
            pending_d = nsc_pkg::V_TRUNC;
            phase_d   = nsc_pkg::PH_DONE;
          end else if (byte_i == nsc_pkg::ChStar) begin
            phase_d = nsc_pkg::PH_HEX1;
          end else begin
            xor_d = xor_q ^ byte_i;
          end
        end
        nsc_pkg::PH_HEX1: begin
          if (byte_i != nsc_pkg::hex_digit(xor_q[7:4])) begin
            pending_d = nsc_pkg::V_CHECKSUM;
            phase_d   = nsc_pkg::PH_DONE;
          end else begin
            phase_d = nsc_pkg::PH_HEX2;
          end
        end
        nsc_pkg::PH_HEX2: begin
          pending_d = (byte_i != nsc_pkg::hex_digit(xor_q[3:0])) ? nsc_pkg::V_CHECKSUM
                                                                 : nsc_pkg::V_OK;
          phase_d   = nsc_pkg::PH_DONE;
        end
        nsc_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase

      prev_cr_d = (byte_i == nsc_pkg::ChCr);

      if (line_end) begin
        res_valid_o   = 1'b1;
        res_o.talker  = talker_d;
        res_o.length  = cnt_d;
        if (cnt_d < 8'(nsc_pkg::MinLine)) begin
          res_o.verdict = nsc_pkg::V_SHORT;
        end else if (overlong_d || phase_d != nsc_pkg::PH_DONE) begin
          res_o.verdict = nsc_pkg::V_TRUNC;
        end else begin
          res_o.verdict = pending_d;
        end
        phase_d      = nsc_pkg::PH_START;
        pending_d    = nsc_pkg::V_OK;
        xor_d        = 8'd0;
        cnt_d        = 8'd0;
        pos_d        = 3'd0;
        start_good_d = 1'b0;
        talker_d     = 8'd0;
        prev_cr_d    = 1'b0;
        overlong_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= nsc_pkg::PH_START;
      pending_q    <= nsc_pkg::V_OK;
      xor_q        <= 8'd0;
      cnt_q        <= 8'd0;
      pos_q        <= 3'd0;
      start_good_q <= 1'b0;
      talker_q     <= 8'd0;
      prev_cr_q    <= 1'b0;
      overlong_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pending_q    <= pending_d;
      xor_q        <= xor_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      start_good_q <= start_good_d;
      talker_q     <= talker_d;
      prev_cr_q    <= prev_cr_d;
      overlong_q   <= overlong_d;
    end
  end

endmodule
